// ===== src/rfifo_pkg.sv =====
// Shared types, codes and widths for the turn-taking ring FIFO.
`timescale 1ns / 1ps
`default_nettype none

package rfifo_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int NUM_PROD_DEF = 5;
  localparam int NUM_CONS_DEF = 5;

  localparam int OP_W    = 2;
  localparam int ID_W    = 3;
  localparam int VAL_W   = 16;
  localparam int STAT_W  = 3;
  localparam int FILL_W  = 5;
  localparam int CAP_W   = 5;
  localparam int CNT_W   = 32;
  localparam int TURN_OW = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [OP_W-1:0] {
    OP_PRODUCE  = 2'd0,
    OP_CONSUME  = 2'd1,
    OP_SHUTDOWN = 2'd2,
    OP_QUERY    = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_TURN    = 3'd3,
    ST_STOPPED = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

endpackage

`default_nettype wire

// ===== src/ring_fifo_with_turn_taking.sv =====
// Top level: ring FIFO shared by round-robin producers and consumers.
`timescale 1ns / 1ps
`default_nettype none

// Each request takes two steps: the accept edge reads the ring slot at the
// read pointer and the requester's produce and consume tallies from their
// memories, and the execute edge checks the request, writes the slot and
// the tally back and loads the output register. The next request is taken
// once that write-back is done. A waiting result sits in the output
// register; the following request is still taken but stays in execution
// until that register frees, and further requests are stalled meanwhile.
// Tallies read as zero after reset through per-entry valid bits, so there
// is no clearing pass. The user must write the capacity register only while
// no request is in flight; the block itself does not enforce this.
module ring_fifo_with_turn_taking import rfifo_pkg::*; #(
  parameter int DEPTH         = DEPTH_DEF,
  parameter int NUM_PRODUCERS = NUM_PROD_DEF,
  parameter int NUM_CONSUMERS = NUM_CONS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [CAP_W-1:0]    cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [OP_W-1:0]     opcode,
  input  wire logic [ID_W-1:0]     requester_id,
  input  wire logic [VAL_W-1:0]    item_value,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STAT_W-1:0]        status,
  output logic [VAL_W-1:0]         item_out,
  output logic [FILL_W-1:0]        fill_level,
  output logic [CNT_W-1:0]         produced_count,
  output logic [CNT_W-1:0]         consumed_count,
  output logic [TURN_OW-1:0]       next_producer,
  output logic [TURN_OW-1:0]       next_consumer
);

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = (AW + 1 > CAP_W) ? AW + 1 : CAP_W;
  localparam int PTW = (NUM_PRODUCERS > 1) ? $clog2(NUM_PRODUCERS) : 1;
  localparam int CTW = (NUM_CONSUMERS > 1) ? $clog2(NUM_CONSUMERS) : 1;
  localparam int PCW = ((PTW > ID_W) ? PTW : ID_W) + 1;
  localparam int CCW = ((CTW > ID_W) ? CTW : ID_W) + 1;

  // memories
  logic [VAL_W-1:0] ring_mem [DEPTH];
  logic [CNT_W-1:0] prod_mem [NUM_PRODUCERS];
  logic [CNT_W-1:0] cons_mem [NUM_CONSUMERS];
  logic [NUM_PRODUCERS-1:0] prod_vld;
  logic [NUM_CONSUMERS-1:0] cons_vld;

  // registers
  state_t           state, state_next;
  logic [CAP_W-1:0] cap;
  logic [AW-1:0]    rd_ptr, rd_ptr_next;
  logic [AW-1:0]    wr_ptr, wr_ptr_next;
  logic [FILL_W-1:0] occ, occ_next;
  logic             active, active_next;
  logic [PTW-1:0]   prod_owner, prod_owner_next;
  logic [CTW-1:0]   cons_owner, cons_owner_next;
  op_t              req_op;
  logic [ID_W-1:0]  req_id;
  logic [VAL_W-1:0] req_val;
  logic [VAL_W-1:0] ring_q;
  logic [CNT_W-1:0] prod_q, cons_q;
  logic             prod_vld_q, cons_vld_q;

  // combinational
  logic             in_xfer, done, load_out;
  logic [CW-1:0]    eff_cap;
  logic [CW-1:0]    wr_step, rd_step;
  logic [PTW:0]     pturn_step;
  logic [CTW:0]     cturn_step;
  logic [PTW-1:0]   in_paddr, req_paddr;
  logic [CTW-1:0]   in_caddr, req_caddr;
  logic             pid_ok, cid_ok;
  logic [CNT_W-1:0] prod_cur, cons_cur, prod_new, cons_new;
  logic             ring_we, prod_we, cons_we;
  status_t          st;
  logic [VAL_W-1:0] item_res;
  logic [CNT_W-1:0] pcnt_res, ccnt_res;

  assign in_xfer   = in_valid && !in_stall;
  assign in_stall  = (state == S_EXEC);
  assign load_out  = done;
  assign in_paddr  = PTW'(requester_id);
  assign in_caddr  = CTW'(requester_id);
  assign req_paddr = PTW'(req_id);
  assign req_caddr = CTW'(req_id);
  assign pid_ok    = (32'(req_id) < NUM_PRODUCERS);
  assign cid_ok    = (32'(req_id) < NUM_CONSUMERS);
  assign prod_cur  = prod_vld_q ? prod_q : '0;
  assign cons_cur  = cons_vld_q ? cons_q : '0;
  assign prod_new  = sat_inc(prod_cur);
  assign cons_new  = sat_inc(cons_cur);

  always_comb begin
    if (cap == '0) begin
      eff_cap = CW'(1);
    end else if (CW'(cap) > CW'(DEPTH)) begin
      eff_cap = CW'(DEPTH);
    end else begin
      eff_cap = CW'(cap);
    end
  end

  assign wr_step    = CW'(wr_ptr) + CW'(1);
  assign rd_step    = CW'(rd_ptr) + CW'(1);
  assign pturn_step = {1'b0, prod_owner} + (PTW+1)'(1);
  assign cturn_step = {1'b0, cons_owner} + (CTW+1)'(1);

  always_comb begin
    state_next      = state;
    done            = 1'b0;
    rd_ptr_next     = rd_ptr;
    wr_ptr_next     = wr_ptr;
    occ_next        = occ;
    active_next     = active;
    prod_owner_next = prod_owner;
    cons_owner_next = cons_owner;
    ring_we         = 1'b0;
    prod_we         = 1'b0;
    cons_we         = 1'b0;
    st              = ST_OK;
    item_res        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid || !out_stall) begin
          done       = 1'b1;
          state_next = S_IDLE;
          unique case (req_op)
            OP_PRODUCE: begin
              if (!active) begin
                st = ST_STOPPED;
              end else if (PCW'(req_id) != PCW'(prod_owner)) begin
                st = ST_TURN;
              end else if (CW'(occ) >= eff_cap) begin
                st = ST_FULL;
              end else begin
                ring_we         = 1'b1;
                prod_we         = 1'b1;
                wr_ptr_next     = (wr_step >= eff_cap) ? '0 : AW'(wr_step);
                occ_next        = occ + FILL_W'(1);
                prod_owner_next = (32'(pturn_step) >= NUM_PRODUCERS) ? '0 : PTW'(pturn_step);
              end
            end
            OP_CONSUME: begin
              if (!active) begin
                st = ST_STOPPED;
              end else if (CCW'(req_id) != CCW'(cons_owner)) begin
                st = ST_TURN;
              end else if (occ == '0) begin
                st = ST_EMPTY;
              end else begin
                cons_we         = 1'b1;
                item_res        = ring_q;
                rd_ptr_next     = (rd_step >= eff_cap) ? '0 : AW'(rd_step);
                occ_next        = occ - FILL_W'(1);
                cons_owner_next = (32'(cturn_step) >= NUM_CONSUMERS) ? '0 : CTW'(cturn_step);
              end
            end
            OP_SHUTDOWN: begin
              active_next = 1'b0;
            end
            OP_QUERY: begin
            end
          endcase
        end
      end
    endcase
  end

  always_comb begin
    pcnt_res = '0;
    ccnt_res = '0;
    if (pid_ok) begin
      pcnt_res = prod_we ? prod_new : prod_cur;
    end
    if (cid_ok) begin
      ccnt_res = cons_we ? cons_new : cons_cur;
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cap        <= CAP_RESET;
      rd_ptr     <= '0;
      wr_ptr     <= '0;
      occ        <= '0;
      active     <= 1'b1;
      prod_owner <= '0;
      cons_owner <= '0;
      prod_vld   <= '0;
      cons_vld   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      rd_ptr     <= rd_ptr_next;
      wr_ptr     <= wr_ptr_next;
      occ        <= occ_next;
      active     <= active_next;
      prod_owner <= prod_owner_next;
      cons_owner <= cons_owner_next;
      if (cfg_we) begin
        cap <= cfg_data;
      end
      if (prod_we) begin
        prod_vld[req_paddr] <= 1'b1;
      end
      if (cons_we) begin
        cons_vld[req_caddr] <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request capture and memory reads
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_op     <= op_t'(opcode);
      req_id     <= requester_id;
      req_val    <= item_value;
      ring_q     <= ring_mem[rd_ptr];
      prod_q     <= prod_mem[in_paddr];
      cons_q     <= cons_mem[in_caddr];
      prod_vld_q <= prod_vld[in_paddr];
      cons_vld_q <= cons_vld[in_caddr];
    end
  end

  // memory write-back
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[wr_ptr] <= req_val;
    end
    if (prod_we) begin
      prod_mem[req_paddr] <= prod_new;
    end
    if (cons_we) begin
      cons_mem[req_caddr] <= cons_new;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      status         <= st;
      item_out       <= item_res;
      fill_level     <= occ_next;
      produced_count <= pcnt_res;
      consumed_count <= ccnt_res;
      next_producer  <= TURN_OW'(prod_owner_next);
      next_consumer  <= TURN_OW'(cons_owner_next);
    end
  end

  a_accept_execs: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == S_EXEC)
    else $error("accepted request did not enter execution");

  a_occ_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (occ == $past(occ) || occ == $past(occ) + FILL_W'(1) ||
              occ == $past(occ) - FILL_W'(1)))
    else $error("occupancy moved by more than one");

  a_stop_sticks: assert property (@(posedge clk) disable iff (rst)
    !active |=> !active)
    else $error("block restarted after shutdown");

  a_write_running: assert property (@(posedge clk) disable iff (rst)
    ring_we |-> active && occ < FILL_W'(eff_cap))
    else $error("slot written while stopped or full");

endmodule

`default_nettype wire

// ===== bench/rfifo_turn_checker.sv =====
// Checker for the turn-taking ring FIFO: predicts each reply and compares it at the output.
`timescale 1ns / 1ps

module rfifo_turn_checker import rfifo_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CAP_W-1:0]    cfg_data,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [OP_W-1:0]     opcode,
  input  logic [ID_W-1:0]     requester_id,
  input  logic [VAL_W-1:0]    item_value,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [STAT_W-1:0]   status,
  input  logic [VAL_W-1:0]    item_out,
  input  logic [FILL_W-1:0]   fill_level,
  input  logic [CNT_W-1:0]    produced_count,
  input  logic [CNT_W-1:0]    consumed_count,
  input  logic [TURN_OW-1:0]  next_producer,
  input  logic [TURN_OW-1:0]  next_consumer,
  output int                  fail_count,
  output int                  pending,
  output logic [FILL_W-1:0]   hint_fill,
  output logic [CAP_W-1:0]    hint_cap,
  output logic [ID_W-1:0]     hint_pturn,
  output logic [ID_W-1:0]     hint_cturn
);

  localparam int PTR_W = $clog2(DEPTH_DEF);

  typedef struct {
    status_t              st;
    logic [VAL_W-1:0]     item;
    logic [FILL_W-1:0]    fill;
    logic [CNT_W-1:0]     pcnt;
    logic [CNT_W-1:0]     ccnt;
    logic [TURN_OW-1:0]   np;
    logic [TURN_OW-1:0]   nc;
  } fifo_reply_t;

  fifo_reply_t        due_replies[$];
  logic [VAL_W-1:0]   slots [DEPTH_DEF];
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W-1:0]   wr_ptr;
  logic [FILL_W-1:0]  held;
  logic               running;
  logic [ID_W-1:0]    p_turn;
  logic [ID_W-1:0]    c_turn;
  logic [CNT_W-1:0]   p_tally [NUM_PROD_DEF];
  logic [CNT_W-1:0]   c_tally [NUM_CONS_DEF];
  logic [CAP_W-1:0]   cap_reg;
  int                 errs = 0;

  assign fail_count = errs;

  function automatic int unsigned span(input logic [CAP_W-1:0] c);
    if (c == '0) return 1;
    if (c > DEPTH_DEF) return DEPTH_DEF;
    return c;
  endfunction

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p,
                                                 input int unsigned lim);
    return (int'(p) + 1 >= lim) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [ID_W-1:0] turn_next(input logic [ID_W-1:0] t,
                                                input int unsigned lim);
    return (int'(t) + 1 >= lim) ? '0 : t + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic fifo_reply_t serve_request(input op_t op, input logic [ID_W-1:0] id,
                                                input logic [VAL_W-1:0] val);
    fifo_reply_t r;
    int unsigned lim;
    lim = span(cap_reg);
    r.st = ST_OK;
    r.item = '0;
    case (op)
      OP_PRODUCE: begin
        if (!running) r.st = ST_STOPPED;
        else if (id != p_turn) r.st = ST_TURN;
        else if (held >= lim) r.st = ST_FULL;
        else begin
          slots[wr_ptr] = val;
          wr_ptr = ring_next(wr_ptr, lim);
          held = held + 1'b1;
          p_tally[p_turn] = bump(p_tally[p_turn]);
          p_turn = turn_next(p_turn, NUM_PROD_DEF);
        end
      end
      OP_CONSUME: begin
        if (!running) r.st = ST_STOPPED;
        else if (id != c_turn) r.st = ST_TURN;
        else if (held == '0) r.st = ST_EMPTY;
        else begin
          r.item = slots[rd_ptr];
          rd_ptr = ring_next(rd_ptr, lim);
          held = held - 1'b1;
          c_tally[c_turn] = bump(c_tally[c_turn]);
          c_turn = turn_next(c_turn, NUM_CONS_DEF);
        end
      end
      OP_SHUTDOWN: running = 1'b0;
      default: ;
    endcase
    r.fill = held;
    r.pcnt = '0;
    r.ccnt = '0;
    if (id < NUM_PROD_DEF) r.pcnt = p_tally[id];
    if (id < NUM_CONS_DEF) r.ccnt = c_tally[id];
    r.np = p_turn;
    r.nc = c_turn;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
                                 input logic [CNT_W-1:0] want);
    if (errs < 100)
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    errs++;
  endtask

  always @(posedge clk) begin
    fifo_reply_t r;
    if (rst) begin
      due_replies.delete();
      rd_ptr = '0;
      wr_ptr = '0;
      held = '0;
      running = 1'b1;
      p_turn = '0;
      c_turn = '0;
      for (int k = 0; k < DEPTH_DEF; k++) slots[k] = '0;
      for (int k = 0; k < NUM_PROD_DEF; k++) p_tally[k] = '0;
      for (int k = 0; k < NUM_CONS_DEF; k++) c_tally[k] = '0;
      cap_reg = CAP_RESET;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_replies.size() == 0) begin
          report_mismatch("reply with no request", status, '0);
        end else begin
          r = due_replies.pop_front();
          if (status !== r.st) report_mismatch("status", status, r.st);
          if (item_out !== r.item) report_mismatch("item_out", item_out, r.item);
          if (fill_level !== r.fill) report_mismatch("fill_level", fill_level, r.fill);
          if (produced_count !== r.pcnt)
            report_mismatch("produced_count", produced_count, r.pcnt);
          if (consumed_count !== r.ccnt)
            report_mismatch("consumed_count", consumed_count, r.ccnt);
          if (next_producer !== r.np) report_mismatch("next_producer", next_producer, r.np);
          if (next_consumer !== r.nc) report_mismatch("next_consumer", next_consumer, r.nc);
        end
      end
      if (cfg_we) cap_reg = cfg_data;
      if (in_valid && !in_stall)
        due_replies.push_back(serve_request(op_t'(opcode), requester_id, item_value));
    end
    pending <= due_replies.size();
    hint_fill <= held;
    hint_cap <= CAP_W'(span(cap_reg));
    hint_pturn <= p_turn;
    hint_cturn <= c_turn;
  end

endmodule

// ===== bench/tb_ring_fifo_with_turn_taking.sv =====
// Testbench top for the turn-taking ring FIFO: drives requests and gives the verdict.
`timescale 1ns / 1ps

module tb_ring_fifo_with_turn_taking import rfifo_pkg::*;;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [CAP_W-1:0]    cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     opcode = '0;
  logic [ID_W-1:0]     requester_id = '0;
  logic [VAL_W-1:0]    item_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STAT_W-1:0]   status;
  logic [VAL_W-1:0]    item_out;
  logic [FILL_W-1:0]   fill_level;
  logic [CNT_W-1:0]    produced_count;
  logic [CNT_W-1:0]    consumed_count;
  logic [TURN_OW-1:0]  next_producer;
  logic [TURN_OW-1:0]  next_consumer;

  int                  fail_count;
  int                  pending;
  logic [FILL_W-1:0]   hint_fill;
  logic [CAP_W-1:0]    hint_cap;
  logic [ID_W-1:0]     hint_pturn;
  logic [ID_W-1:0]     hint_cturn;

  int                  stall_pct = 0;
  int                  gap_pct = 0;
  int                  cap_plan [8] = '{16, 1, 0, 31, 5, 17, 2, 9};

  ring_fifo_with_turn_taking u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .requester_id   (requester_id),
    .item_value     (item_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .item_out       (item_out),
    .fill_level     (fill_level),
    .produced_count (produced_count),
    .consumed_count (consumed_count),
    .next_producer  (next_producer),
    .next_consumer  (next_consumer)
  );

  rfifo_turn_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .requester_id   (requester_id),
    .item_value     (item_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .item_out       (item_out),
    .fill_level     (fill_level),
    .produced_count (produced_count),
    .consumed_count (consumed_count),
    .next_producer  (next_producer),
    .next_consumer  (next_consumer),
    .fail_count     (fail_count),
    .pending        (pending),
    .hint_fill      (hint_fill),
    .hint_cap       (hint_cap),
    .hint_pturn     (hint_pturn),
    .hint_cturn     (hint_cturn)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic push_item(input op_t op, input logic [ID_W-1:0] id,
                           input logic [VAL_W-1:0] val);
    in_valid <= 1'b1;
    opcode <= op;
    requester_id <= id;
    item_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_gap();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    idle_gap();
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_cap(input logic [CAP_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int n_items);
    op_t op;
    logic [ID_W-1:0] id;
    logic [VAL_W-1:0] val;
    int roll;
    bit filling = 1'b1;
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        op = op_t'($urandom_range(0, 2));
        if (op == OP_SHUTDOWN) op = OP_QUERY;
        push_item(op, ID_W'($urandom_range(0, 7)), VAL_W'($urandom));
      end else begin
        idle_gap();
        while ($urandom_range(0, 99) < gap_pct) idle_gap();
        if (hint_fill >= hint_cap) filling = 1'b0;
        else if (hint_fill == '0) filling = 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          op = OP_QUERY;
          id = ID_W'($urandom_range(0, 7));
        end else begin
          op = ($urandom_range(0, 99) < (filling ? 75 : 25)) ? OP_PRODUCE : OP_CONSUME;
          id = (op == OP_PRODUCE) ? hint_pturn : hint_cturn;
          if ($urandom_range(0, 99) < 10) id = ID_W'($urandom_range(0, 7));
        end
        roll = $urandom_range(0, 15);
        val = (roll == 0) ? '0 : (roll == 1) ? '1 : VAL_W'($urandom);
        push_item(op, id, val);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_cap(CAP_RESET);

    push_item(OP_CONSUME, 3'd0, '0);
    push_item(OP_CONSUME, 3'd3, '0);
    push_item(OP_PRODUCE, 3'd2, 16'h1234);
    push_item(OP_PRODUCE, 3'd5, 16'h4321);
    push_item(OP_CONSUME, 3'd7, '0);
    push_item(OP_QUERY, 3'd6, '1);
    for (int k = 0; k < DEPTH_DEF; k++)
      push_item(OP_PRODUCE, ID_W'(k % NUM_PROD_DEF),
                (k == 0) ? '0 : (k == 1) ? '1 : VAL_W'($urandom));
    push_item(OP_PRODUCE, ID_W'(DEPTH_DEF % NUM_PROD_DEF), 16'hA5A5);
    push_item(OP_QUERY, 3'd1, '0);

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      if (ph == 7) cap_plan[ph] = $urandom_range(0, 31);
      set_cap(CAP_W'(cap_plan[ph]));
      case (ph % 4)
        0: begin
          gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct = 72;
          stall_pct = 0;
        end
        2: begin
          gap_pct = 0;
          stall_pct = 72;
        end
        default: begin
          gap_pct = 13;
          stall_pct = 13;
        end
      endcase
      run_phase(235);
    end

    wait_idle();
    push_item(OP_SHUTDOWN, ID_W'($urandom_range(0, 7)), VAL_W'($urandom));
    for (int k = 0; k < 30; k++) begin
      idle_gap();
      while ($urandom_range(0, 99) < gap_pct) idle_gap();
      push_item(op_t'($urandom_range(0, 3)), ID_W'($urandom_range(0, 7)), VAL_W'($urandom));
    end

    wait_idle();
    stall_pct = 0;
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("** ring_fifo_with_turn_taking: PASSED **");
    end else begin
      $display("** ring_fifo_with_turn_taking: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** ring_fifo_with_turn_taking: FAILED **");
    $finish;
  end

endmodule
